[src/iee_pkg.sv]
// Shared types, constants and helper functions of the infix expression evaluator.
package iee_pkg;

    localparam int STACK_DEPTH   = 32;
    localparam int FRACTION_BITS = 32;
    localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W         = $clog2(STACK_DEPTH);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_DIV0 = 2'd1;
    localparam logic [1:0] ERR_SAT  = 2'd2;
    localparam logic [1:0] ERR_BAD  = 2'd3;

    localparam int NF_PEND  = 0;
    localparam int NF_POINT = 1;
    localparam int NF_AFTER = 2;

    localparam logic [63:0] ACC_CAP  = 64'd100000000000000000;
    localparam logic [63:0] ACC_FULL = 64'd999999999999999999;
    localparam logic [63:0] FX_MIN   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] FX_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        OPC_LPAR = 3'd0,
        OPC_ADD  = 3'd1,
        OPC_SUB  = 3'd2,
        OPC_MUL  = 3'd3,
        OPC_DIV  = 3'd4
    } t_opc;

    typedef enum logic [1:0] {
        CTX_CHAR,
        CTX_OP,
        CTX_RPAR,
        CTX_END
    } t_ctx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_TAIL,
        S_FLUSH,
        S_CONVW,
        S_CHKAFTER,
        S_LOOP,
        S_LOOPCHK,
        S_APPLY,
        S_RDB,
        S_RDA,
        S_UWAIT,
        S_EXIT,
        S_RES,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        U_IDLE,
        U_MUL,
        U_DIV,
        U_FIN
    } t_ustate;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_mark;
    } t_in;

    typedef struct packed {
        logic signed [63:0] value;
        logic [1:0]         error_code;
    } t_out;

    typedef struct packed {
        logic        start;
        t_opc        op;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
        logic [1:0]  err;
    } t_alu_rsp;

    function automatic logic [63:0] dec_pow(input logic [4:0] fd);
        case (fd)
            5'd0:    return 64'd1;
            5'd1:    return 64'd10;
            5'd2:    return 64'd100;
            5'd3:    return 64'd1000;
            5'd4:    return 64'd10000;
            5'd5:    return 64'd100000;
            5'd6:    return 64'd1000000;
            5'd7:    return 64'd10000000;
            5'd8:    return 64'd100000000;
            5'd9:    return 64'd1000000000;
            5'd10:   return 64'd10000000000;
            5'd11:   return 64'd100000000000;
            5'd12:   return 64'd1000000000000;
            5'd13:   return 64'd10000000000000;
            5'd14:   return 64'd100000000000000;
            5'd15:   return 64'd1000000000000000;
            5'd16:   return 64'd10000000000000000;
            5'd17:   return 64'd100000000000000000;
            default: return 64'd1000000000000000000;
        endcase
    endfunction

    function automatic logic [1:0] prec(input t_opc op);
        if (op == OPC_MUL || op == OPC_DIV) return 2'd2;
        if (op == OPC_LPAR) return 2'd0;
        return 2'd1;
    endfunction

    // code 3 always wins, otherwise the first nonzero code sticks
    function automatic logic [1:0] raise(input logic [1:0] cur, input logic [1:0] code);
        if (code == ERR_NONE) return cur;
        if (code == ERR_BAD || cur == ERR_NONE) return code;
        return cur;
    endfunction

endpackage

[src/iee_alu.sv]
// Shared iterative arithmetic unit: saturating add/sub, fixed-point multiply and divide.
module iee_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iee_pkg::t_alu_req i_req,
    output iee_pkg::t_alu_rsp o_rsp
);
    import iee_pkg::*;

    localparam int DIV_STEPS = 64 + FRACTION_BITS;
    localparam int CW        = $clog2(DIV_STEPS);

    t_ustate      r_ust, n_ust;
    logic [CW-1:0] r_cnt, n_cnt;
    logic         r_neg, n_neg;
    logic         r_ovf, n_ovf;
    logic         r_mul, n_mul;
    logic [63:0]  r_x, n_x;
    logic [63:0]  r_y, n_y;
    logic [63:0]  r_q, n_q;
    logic [63:0]  r_r, n_r;
    logic [63:0]  r_pp, n_pp;
    logic [127:0] r_prod, n_prod;
    logic         r_done, n_done;
    logic [63:0]  r_res, n_res;
    logic [1:0]   r_err, n_err;

    logic [63:0]  mag_a, mag_b;
    logic [64:0]  sum;
    logic [64:0]  rem65, diff65;
    logic         ge;
    logic [31:0]  xs, ys;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] rnd_prod;
    logic         rnd;
    logic [64:0]  qm;
    logic [64:0]  fm;

    function automatic logic [64:0] from_mag(input logic neg, input logic [64:0] mag);
        if (neg) begin
            if (mag > {1'b0, FX_MIN}) return {1'b1, FX_MIN};
            return {1'b0, ~mag[63:0] + 64'd1};
        end
        if (mag > {1'b0, FX_MAX}) return {1'b1, FX_MAX};
        return {1'b0, mag[63:0]};
    endfunction

    assign o_rsp = '{done: r_done, result: r_res, err: r_err};

    always_comb begin
        n_ust  = r_ust;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_ovf  = r_ovf;
        n_mul  = r_mul;
        n_x    = r_x;
        n_y    = r_y;
        n_q    = r_q;
        n_r    = r_r;
        n_pp   = r_pp;
        n_prod = r_prod;
        n_done = 1'b0;
        n_res  = r_res;
        n_err  = r_err;

        mag_a = i_req.a[63] ? ~i_req.a + 64'd1 : i_req.a;
        mag_b = i_req.b[63] ? ~i_req.b + 64'd1 : i_req.b;
        if (i_req.op == OPC_SUB) sum = {i_req.a[63], i_req.a} - {i_req.b[63], i_req.b};
        else                     sum = {i_req.a[63], i_req.a} + {i_req.b[63], i_req.b};

        rem65  = {r_r, r_x[63]};
        diff65 = rem65 - {1'b0, r_y};
        ge     = rem65 >= {1'b0, r_y};

        xs    = r_cnt[1] ? r_x[63:32] : r_x[31:0];
        ys    = r_cnt[0] ? r_y[63:32] : r_y[31:0];
        pp    = 64'(xs) * 64'(ys);
        if (r_cnt == CW'(1))      pp_sh = {64'd0, r_pp};
        else if (r_cnt == CW'(4)) pp_sh = {r_pp, 64'd0};
        else                      pp_sh = {32'd0, r_pp, 32'd0};

        rnd_prod = r_prod + (128'd1 << (FRACTION_BITS - 1));
        rnd      = r_r >= (r_y - r_r);
        qm       = {1'b0, r_q} + {64'd0, rnd};
        fm       = '0;

        unique case (r_ust)
            U_IDLE: begin
                if (i_req.start) begin
                    n_neg = i_req.a[63] ^ i_req.b[63];
                    n_x   = mag_a;
                    n_y   = mag_b;
                    n_cnt = '0;
                    n_ovf = 1'b0;
                    n_q   = '0;
                    n_r   = '0;
                    n_prod = '0;
                    n_err = ERR_NONE;
                    unique case (i_req.op)
                        OPC_ADD, OPC_SUB: begin
                            n_done = 1'b1;
                            if (sum[64] != sum[63]) begin
                                n_res = sum[64] ? FX_MIN : FX_MAX;
                                n_err = ERR_SAT;
                            end else begin
                                n_res = sum[63:0];
                            end
                        end
                        OPC_MUL: begin
                            n_mul = 1'b1;
                            n_ust = U_MUL;
                        end
                        OPC_DIV: begin
                            n_mul = 1'b0;
                            if (i_req.b == 64'd0) begin
                                n_done = 1'b1;
                                n_err  = ERR_DIV0;
                                if (i_req.a == 64'd0) n_res = 64'd0;
                                else n_res = i_req.a[63] ? FX_MIN : FX_MAX;
                            end else begin
                                n_ust = U_DIV;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                            n_res  = i_req.a;
                            n_err  = ERR_BAD;
                        end
                    endcase
                end
            end
            U_MUL: begin
                // partial product registered, then accumulated in the next cycle
                if (r_cnt < CW'(4)) n_pp = pp;
                if (r_cnt != '0) n_prod = r_prod + pp_sh;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(4)) n_ust = U_FIN;
            end
            U_DIV: begin
                n_x   = {r_x[62:0], 1'b0};
                n_r   = ge ? diff65[63:0] : rem65[63:0];
                n_q   = {r_q[62:0], ge};
                n_ovf = r_ovf | r_q[63];
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(DIV_STEPS - 1)) n_ust = U_FIN;
            end
            U_FIN: begin
                n_done = 1'b1;
                n_ust  = U_IDLE;
                if (r_mul) begin
                    if (|rnd_prod[127:64+FRACTION_BITS]) begin
                        n_res = r_neg ? FX_MIN : FX_MAX;
                        n_err = ERR_SAT;
                    end else begin
                        fm    = from_mag(r_neg, {1'b0, rnd_prod[63+FRACTION_BITS:FRACTION_BITS]});
                        n_res = fm[63:0];
                        n_err = fm[64] ? ERR_SAT : ERR_NONE;
                    end
                end else begin
                    if (r_ovf || qm[64]) begin
                        n_res = r_neg ? FX_MIN : FX_MAX;
                        n_err = ERR_SAT;
                    end else begin
                        fm    = from_mag(r_neg, qm);
                        n_res = fm[63:0];
                        n_err = fm[64] ? ERR_SAT : ERR_NONE;
                    end
                end
            end
            default: n_ust = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ust  <= U_IDLE;
            r_done <= 1'b0;
        end else begin
            r_ust  <= n_ust;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_ovf  <= n_ovf;
        r_mul  <= n_mul;
        r_x    <= n_x;
        r_y    <= n_y;
        r_q    <= n_q;
        r_r    <= n_r;
        r_pp   <= n_pp;
        r_prod <= n_prod;
        r_res  <= n_res;
        r_err  <= n_err;
    end

endmodule

[src/infix_expression_evaluator.sv]
// Top level: character sequencer, operand/operator stacks and result register.
//
//  channel | valid   | stall   | payload                        | dir
//  input   | i_valid | o_stall | i_data  (symbol, end_mark)     | in
//  result  | o_valid | i_stall | o_data  (value, error_code)    | out
//
// Digits, points and ignored characters pass through dispatch and tail; an end-marked
// beat adds the final reductions. Each reduction of +, -, * or / runs on the shared arithmetic
// unit. Ending a number costs one divider pass for the decimal-to-fixed conversion.
// Synchronous active-low reset clears counts, flags and the error latch; stacks need no clear.
// o_stall is high while a beat is worked on, also while a new result waits on a held one.
module infix_expression_evaluator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  iee_pkg::t_in  i_data,
    output logic          o_stall,
    output logic          o_valid,
    output iee_pkg::t_out o_data,
    input  logic          i_stall
);
    import iee_pkg::*;

    t_state           r_state, n_state;
    logic [7:0]       r_sym, n_sym;
    logic             r_end, n_end;
    t_ctx             r_ctx, n_ctx;
    t_opc             r_op, n_op;
    t_opc             r_top, n_top;
    logic [63:0]      r_b, n_b;
    logic [63:0]      r_val, n_val;
    logic [63:0]      r_acc, n_acc;
    logic [4:0]       r_fd, n_fd;
    logic [2:0]       r_flags, n_flags;
    logic [1:0]       r_err, n_err;
    logic [CNT_W-1:0] r_opnd_cnt, n_opnd_cnt;
    logic [CNT_W-1:0] r_oper_cnt, n_oper_cnt;
    logic             r_ovalid, n_ovalid;
    t_out             r_odata, n_odata;

    logic [63:0]      r_opnd_mem [STACK_DEPTH];
    t_opc             r_oper_mem [STACK_DEPTH];
    logic [63:0]      r_opnd_rd;
    t_opc             r_oper_rd;

    logic             opnd_we, oper_we;
    logic [IDX_W-1:0] opnd_waddr, opnd_raddr, oper_waddr, oper_raddr;
    logic [63:0]      opnd_wdata;
    t_opc             oper_wdata;

    logic [CNT_W-1:0] opnd_m1, opnd_m2, oper_m1;

    t_alu_req         alu_req;
    t_alu_rsp         alu_rsp;

    iee_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    assign opnd_m1 = r_opnd_cnt - CNT_W'(1);
    assign opnd_m2 = r_opnd_cnt - CNT_W'(2);
    assign oper_m1 = r_oper_cnt - CNT_W'(1);

    always_comb begin
        n_state    = r_state;
        n_sym      = r_sym;
        n_end      = r_end;
        n_ctx      = r_ctx;
        n_op       = r_op;
        n_top      = r_top;
        n_b        = r_b;
        n_val      = r_val;
        n_acc      = r_acc;
        n_fd       = r_fd;
        n_flags    = r_flags;
        n_err      = r_err;
        n_opnd_cnt = r_opnd_cnt;
        n_oper_cnt = r_oper_cnt;
        n_ovalid   = r_ovalid & i_stall;
        n_odata    = r_odata;

        opnd_we    = 1'b0;
        opnd_waddr = '0;
        opnd_wdata = '0;
        opnd_raddr = '0;
        oper_we    = 1'b0;
        oper_waddr = '0;
        oper_wdata = OPC_LPAR;
        oper_raddr = '0;
        alu_req    = '{start: 1'b0, op: OPC_DIV, a: r_acc, b: dec_pow(r_fd)};

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sym   = i_data.symbol;
                    n_end   = i_data.end_mark;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_ctx   = CTX_CHAR;
                n_state = S_TAIL;
                if (r_err != ERR_BAD) begin
                    unique case (r_sym) inside
                        [CH_0:CH_9], CH_POINT: begin
                            if (r_flags[NF_AFTER] && !r_flags[NF_PEND]) begin
                                n_err = ERR_BAD;
                            end else begin
                                n_flags[NF_PEND] = 1'b1;
                                if (r_sym == CH_POINT) begin
                                    if (r_flags[NF_POINT]) n_err = ERR_BAD;
                                    n_flags[NF_POINT] = 1'b1;
                                end else if (r_acc >= ACC_CAP) begin
                                    if (!r_flags[NF_POINT]) n_acc = ACC_FULL;
                                end else begin
                                    n_acc = (r_acc << 3) + (r_acc << 1) + {60'd0, r_sym[3:0]};
                                    // count sticks at the top; anything past 18 reads as 18
                                    if (r_flags[NF_POINT] && r_fd != 5'd31) n_fd = r_fd + 5'd1;
                                end
                            end
                        end
                        CH_LPAR: begin
                            if (r_flags[NF_AFTER] || r_flags[NF_PEND]) begin
                                n_err = ERR_BAD;
                            end else if (r_oper_cnt == CNT_W'(STACK_DEPTH)) begin
                                n_err = ERR_BAD;
                            end else begin
                                oper_we    = 1'b1;
                                oper_waddr = r_oper_cnt[IDX_W-1:0];
                                oper_wdata = OPC_LPAR;
                                n_oper_cnt = r_oper_cnt + CNT_W'(1);
                            end
                        end
                        CH_RPAR: begin
                            n_ctx   = CTX_RPAR;
                            n_state = S_FLUSH;
                        end
                        CH_PLUS: begin
                            n_ctx = CTX_OP; n_op = OPC_ADD; n_state = S_FLUSH;
                        end
                        CH_MINUS: begin
                            n_ctx = CTX_OP; n_op = OPC_SUB; n_state = S_FLUSH;
                        end
                        CH_STAR: begin
                            n_ctx = CTX_OP; n_op = OPC_MUL; n_state = S_FLUSH;
                        end
                        CH_SLASH: begin
                            n_ctx = CTX_OP; n_op = OPC_DIV; n_state = S_FLUSH;
                        end
                        default: n_state = S_TAIL;
                    endcase
                end
            end
            S_TAIL: begin
                if (r_end && r_ctx != CTX_END && r_err != ERR_BAD) begin
                    n_ctx   = CTX_END;
                    n_state = S_FLUSH;
                end else if (r_end) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (!r_flags[NF_PEND]) begin
                    n_state = S_CHKAFTER;
                end else begin
                    alu_req.start = 1'b1;
                    n_state       = S_CONVW;
                end
            end
            S_CONVW: begin
                if (alu_rsp.done) begin
                    n_err = raise(r_err, alu_rsp.err);
                    if (r_opnd_cnt == CNT_W'(STACK_DEPTH)) begin
                        n_err = ERR_BAD;
                    end else begin
                        opnd_we    = 1'b1;
                        opnd_waddr = r_opnd_cnt[IDX_W-1:0];
                        opnd_wdata = alu_rsp.result;
                        n_opnd_cnt = r_opnd_cnt + CNT_W'(1);
                    end
                    n_acc   = '0;
                    n_fd    = '0;
                    n_flags = 3'b100;
                    n_state = S_CHKAFTER;
                end
            end
            S_CHKAFTER: begin
                if (r_err == ERR_BAD) begin
                    n_state = S_TAIL;
                end else if (!r_flags[NF_AFTER]) begin
                    n_err   = ERR_BAD;
                    n_state = S_TAIL;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                if (r_err == ERR_BAD) begin
                    n_state = S_TAIL;
                end else if (r_oper_cnt == '0) begin
                    n_state = S_EXIT;
                end else begin
                    oper_raddr = oper_m1[IDX_W-1:0];
                    n_state    = S_LOOPCHK;
                end
            end
            S_LOOPCHK: begin
                n_top = r_oper_rd;
                unique case (r_ctx)
                    CTX_OP:   n_state = (prec(r_oper_rd) >= prec(r_op)) ? S_APPLY : S_EXIT;
                    CTX_RPAR: n_state = (r_oper_rd != OPC_LPAR) ? S_APPLY : S_EXIT;
                    CTX_END: begin
                        if (r_oper_rd == OPC_LPAR) begin
                            n_err   = ERR_BAD;
                            n_state = S_TAIL;
                        end else begin
                            n_state = S_APPLY;
                        end
                    end
                    default: n_state = S_TAIL;
                endcase
            end
            S_APPLY: begin
                if (r_opnd_cnt < CNT_W'(2)) begin
                    n_err   = ERR_BAD;
                    n_state = S_TAIL;
                end else begin
                    opnd_raddr = opnd_m1[IDX_W-1:0];
                    n_state    = S_RDB;
                end
            end
            S_RDB: begin
                n_b        = r_opnd_rd;
                opnd_raddr = opnd_m2[IDX_W-1:0];
                n_state    = S_RDA;
            end
            S_RDA: begin
                if (r_top == OPC_LPAR) begin
                    n_err   = ERR_BAD;
                    n_state = S_TAIL;
                end else begin
                    alu_req    = '{start: 1'b1, op: r_top, a: r_opnd_rd, b: r_b};
                    n_oper_cnt = oper_m1;
                    n_opnd_cnt = opnd_m1;
                    n_state    = S_UWAIT;
                end
            end
            S_UWAIT: begin
                if (alu_rsp.done) begin
                    n_err      = raise(r_err, alu_rsp.err);
                    opnd_we    = 1'b1;
                    opnd_waddr = opnd_m1[IDX_W-1:0];
                    opnd_wdata = alu_rsp.result;
                    n_state    = S_LOOP;
                end
            end
            S_EXIT: begin
                n_state = S_TAIL;
                unique case (r_ctx)
                    CTX_OP: begin
                        if (r_oper_cnt == CNT_W'(STACK_DEPTH)) begin
                            n_err = ERR_BAD;
                        end else begin
                            oper_we    = 1'b1;
                            oper_waddr = r_oper_cnt[IDX_W-1:0];
                            oper_wdata = r_op;
                            n_oper_cnt = r_oper_cnt + CNT_W'(1);
                        end
                        n_flags = '0;
                    end
                    CTX_RPAR: begin
                        if (r_oper_cnt == '0) n_err = ERR_BAD;
                        else n_oper_cnt = oper_m1;
                    end
                    CTX_END: begin
                        if (r_opnd_cnt != CNT_W'(1)) begin
                            n_err = ERR_BAD;
                        end else begin
                            opnd_raddr = '0;
                            n_state    = S_RES;
                        end
                    end
                    default: n_state = S_TAIL;
                endcase
            end
            S_RES: begin
                n_val   = r_opnd_rd;
                n_state = S_TAIL;
            end
            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid           = 1'b1;
                    n_odata.value      = (r_err == ERR_BAD) ? 64'sd0 : $signed(r_val);
                    n_odata.error_code = r_err;
                    n_opnd_cnt         = '0;
                    n_oper_cnt         = '0;
                    n_acc              = '0;
                    n_fd               = '0;
                    n_flags            = '0;
                    n_err              = ERR_NONE;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_acc      <= '0;
            r_fd       <= '0;
            r_flags    <= '0;
            r_err      <= ERR_NONE;
            r_opnd_cnt <= '0;
            r_oper_cnt <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_acc      <= n_acc;
            r_fd       <= n_fd;
            r_flags    <= n_flags;
            r_err      <= n_err;
            r_opnd_cnt <= n_opnd_cnt;
            r_oper_cnt <= n_oper_cnt;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym   <= n_sym;
        r_end   <= n_end;
        r_ctx   <= n_ctx;
        r_op    <= n_op;
        r_top   <= n_top;
        r_b     <= n_b;
        r_val   <= n_val;
        r_odata <= n_odata;
    end

    always_ff @(posedge i_clk) begin
        if (opnd_we) r_opnd_mem[opnd_waddr] <= opnd_wdata;
        r_opnd_rd <= r_opnd_mem[opnd_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (oper_we) r_oper_mem[oper_waddr] <= oper_wdata;
        r_oper_rd <= r_oper_mem[oper_raddr];
    end

endmodule

[bench/infix_expression_evaluator_tb.sv]
// Testbench for the infix expression evaluator: directed and random expressions checked against a predictor.
module infix_expression_evaluator_tb;
    import iee_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    t_in i_data = '0;
    logic o_stall;
    logic o_valid;
    t_out o_data;
    logic i_stall = 1'b0;

    infix_expression_evaluator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_data(i_data),
        .o_stall(o_stall), .o_valid(o_valid), .o_data(o_data), .i_stall(i_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_in char_q[$];
    t_out result_q[$];
    int cyc = 0;
    int fail_cnt = 0;
    int expr_cnt = 0;
    logic in_taken = 1'b0;

    // predictor state
    logic signed [63:0] opnd_stk[STACK_DEPTH];
    int opnd_n;
    t_opc opr_stk[STACK_DEPTH];
    int opr_n;
    logic [63:0] num_acc;
    int frac_dig;
    bit num_pend, num_point, num_after;
    logic [1:0] calc_err;

    function automatic void calc_clear();
        opnd_n = 0;
        opr_n = 0;
        num_acc = '0;
        frac_dig = 0;
        num_pend = 0;
        num_point = 0;
        num_after = 0;
        calc_err = ERR_NONE;
    endfunction

    function automatic void note_err(logic [1:0] code);
        if (code == ERR_BAD || calc_err == ERR_NONE) calc_err = code;
    endfunction

    function automatic logic signed [63:0] clamp_to(bit neg);
        note_err(ERR_SAT);
        return neg ? FX_MIN : FX_MAX;
    endfunction

    function automatic logic signed [63:0] signed_of(bit neg, logic [63:0] mag);
        if (neg) begin
            if (mag > FX_MIN) return clamp_to(1'b1);
            return -mag;
        end
        if (mag > FX_MAX) return clamp_to(1'b0);
        return mag;
    endfunction

    function automatic logic [63:0] abs_of(logic signed [63:0] a);
        return a[63] ? -a : a;
    endfunction

    function automatic logic signed [63:0] acc_to_fixed();
        int fd;
        logic [63:0] d, q, r, frac;
        fd = frac_dig > 18 ? 18 : frac_dig;
        d = 64'd1;
        for (int i = 0; i < fd; i++) d = d * 10;
        q = num_acc / d;
        r = num_acc % d;
        frac = '0;
        for (int i = 0; i < FRACTION_BITS; i++) begin
            r = r << 1;
            frac = frac << 1;
            if (r >= d) begin
                r = r - d;
                frac[0] = 1'b1;
            end
        end
        if (r >= d - r) frac = frac + 1;
        if (q > (FX_MAX >> FRACTION_BITS)) return clamp_to(1'b0);
        return signed_of(1'b0, (q << FRACTION_BITS) + frac);
    endfunction

    function automatic logic signed [63:0] fx_product(logic signed [63:0] a,
                                                     logic signed [63:0] b);
        bit neg;
        logic [127:0] p;
        neg = a[63] != b[63];
        p = {64'd0, abs_of(a)} * {64'd0, abs_of(b)} + (128'd1 << (FRACTION_BITS - 1));
        if ((p >> (64 + FRACTION_BITS)) != 0) return clamp_to(neg);
        return signed_of(neg, p[FRACTION_BITS +: 64]);
    endfunction

    function automatic logic signed [63:0] fx_quotient(logic signed [63:0] a,
                                                      logic signed [63:0] b);
        bit neg;
        logic [127:0] num, y, q, r;
        neg = a[63] != b[63];
        if (b == 0) begin
            note_err(ERR_DIV0);
            if (a == 0) return '0;
            return a[63] ? FX_MIN : FX_MAX;
        end
        y = {64'd0, abs_of(b)};
        num = {64'd0, abs_of(a)} << FRACTION_BITS;
        q = num / y;
        r = num % y;
        if (r >= y - r) q = q + 1;
        if ((q >> 64) != 0) return clamp_to(neg);
        return signed_of(neg, q[63:0]);
    endfunction

    function automatic void reduce_top();
        t_opc op;
        logic signed [63:0] a, b, v;
        logic signed [64:0] s;
        if (opr_n == 0 || opnd_n < 2) begin
            note_err(ERR_BAD);
            return;
        end
        opr_n--;
        op = opr_stk[opr_n];
        opnd_n--;
        b = opnd_stk[opnd_n];
        a = opnd_stk[opnd_n - 1];
        case (op)
            OPC_ADD, OPC_SUB: begin
                s = (op == OPC_ADD) ? {a[63], a} + {b[63], b} : {a[63], a} - {b[63], b};
                v = (s[64] != s[63]) ? clamp_to(s[64]) : s[63:0];
            end
            OPC_MUL: v = fx_product(a, b);
            OPC_DIV: v = fx_quotient(a, b);
            default: begin
                note_err(ERR_BAD);
                return;
            end
        endcase
        opnd_stk[opnd_n - 1] = v;
    endfunction

    function automatic void end_number();
        logic signed [63:0] v;
        if (!num_pend) return;
        v = acc_to_fixed();
        if (opnd_n >= STACK_DEPTH) note_err(ERR_BAD);
        else opnd_stk[opnd_n++] = v;
        num_acc = '0;
        frac_dig = 0;
        num_pend = 0;
        num_point = 0;
        num_after = 1;
    endfunction

    function automatic int rank(t_opc op);
        if (op == OPC_MUL || op == OPC_DIV) return 2;
        return (op == OPC_LPAR) ? 0 : 1;
    endfunction

    function automatic void push_op(t_opc op);
        if (opr_n >= STACK_DEPTH) note_err(ERR_BAD);
        else opr_stk[opr_n++] = op;
    endfunction

    function automatic void take_char(logic [7:0] c);
        t_opc op;
        if ((c >= CH_0 && c <= CH_9) || c == CH_POINT) begin
            if (num_after && !num_pend) begin
                note_err(ERR_BAD);
                return;
            end
            num_pend = 1;
            if (c == CH_POINT) begin
                if (num_point) note_err(ERR_BAD);
                num_point = 1;
                return;
            end
            if (num_acc >= ACC_CAP) begin
                if (!num_point) num_acc = ACC_FULL;
                return;
            end
            num_acc = num_acc * 10 + (c - CH_0);
            if (num_point) frac_dig++;
            return;
        end
        case (c)
            CH_PLUS:  op = OPC_ADD;
            CH_MINUS: op = OPC_SUB;
            CH_STAR:  op = OPC_MUL;
            CH_SLASH: op = OPC_DIV;
            CH_LPAR: begin
                if (num_after || num_pend) note_err(ERR_BAD);
                else push_op(OPC_LPAR);
                return;
            end
            CH_RPAR: begin
                end_number();
                if (!num_after) begin
                    note_err(ERR_BAD);
                    return;
                end
                while (calc_err != ERR_BAD && opr_n > 0 && opr_stk[opr_n - 1] != OPC_LPAR)
                    reduce_top();
                if (calc_err == ERR_BAD) return;
                if (opr_n == 0) note_err(ERR_BAD);
                else opr_n--;
                return;
            end
            default: return;
        endcase
        end_number();
        if (!num_after) begin
            note_err(ERR_BAD);
            return;
        end
        while (calc_err != ERR_BAD && opr_n > 0 && rank(opr_stk[opr_n - 1]) >= rank(op))
            reduce_top();
        push_op(op);
        num_pend = 0;
        num_point = 0;
        num_after = 0;
    endfunction

    function automatic void eval_beat(t_in it);
        t_out r;
        if (calc_err != ERR_BAD) take_char(it.symbol);
        if (!it.end_mark) return;
        r.value = '0;
        if (calc_err != ERR_BAD) begin
            end_number();
            if (!num_after) note_err(ERR_BAD);
            while (calc_err != ERR_BAD && opr_n > 0) begin
                if (opr_stk[opr_n - 1] == OPC_LPAR) note_err(ERR_BAD);
                else reduce_top();
            end
            if (calc_err != ERR_BAD && opnd_n != 1) note_err(ERR_BAD);
            if (calc_err != ERR_BAD) r.value = opnd_stk[0];
        end
        r.error_code = calc_err;
        result_q.push_back(r);
        calc_clear();
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0d: %s", cyc, msg);
        fail_cnt++;
    endtask

    // stimulus building
    function automatic void queue_text(string s);
        t_in it;
        if (s.len() == 0) begin
            it.symbol = "x";
            it.end_mark = 1'b1;
            char_q.push_back(it);
        end
        for (int i = 0; i < s.len(); i++) begin
            it.symbol = s[i];
            it.end_mark = (i == s.len() - 1);
            char_q.push_back(it);
        end
        expr_cnt++;
    endfunction

    function automatic string make_number();
        string s;
        int n;
        s = "";
        case ($urandom_range(0, 7))
            0: s = "0";
            1: n = $urandom_range(1, 15);
            2: n = $urandom_range(8, 20);
            default: n = $urandom_range(1, 3);
        endcase
        if (s == "") for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(48, 57)))};
        if ($urandom_range(0, 2) == 0) begin
            s = {s, "."};
            n = $urandom_range(0, 4) == 0 ? $urandom_range(5, 22) : $urandom_range(0, 3);
            for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(48, 57)))};
        end
        return s;
    endfunction

    function automatic string make_expr(int depth);
        string s, ops;
        int n;
        ops = "+-*/";
        n = $urandom_range(1, 4);
        s = "";
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                s = {s, string'(ops[$urandom_range(0, 3)])};
                if ($urandom_range(0, 7) == 0) s = {s, " "};
            end
            if (depth > 0 && $urandom_range(0, 3) == 0)
                s = {s, "(", make_expr(depth - 1), ")"};
            else
                s = {s, make_number()};
        end
        return s;
    endfunction

    function automatic string break_expr(string s);
        string pool;
        pool = "+-*/().0 9";
        if (s.len() == 0) return s;
        if ($urandom_range(0, 1) == 0)
            s[$urandom_range(0, s.len() - 1)] = pool[$urandom_range(0, pool.len() - 1)];
        else
            s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(0, 255));
        return s;
    endfunction

    function automatic bit idle_now();
        if (cyc >= 8000 && cyc < 12000) return 1'b0;
        return $urandom_range(0, 99) < 11;
    endfunction

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (char_q.size() > 0 && !idle_now()) begin
                i_valid <= 1'b1;
                i_data <= char_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off
    int hold_left = 0;
    always @(negedge i_clk) begin
        bit s;
        if (cyc == 3000) hold_left = 2500;
        if (hold_left > 0) begin
            hold_left--;
            s = 1'b1;
        end else begin
            s = i_rst_n && idle_now();
        end
        i_stall <= s;
    end

    // monitor
    always @(posedge i_clk) begin
        t_out want;
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) eval_beat(i_data);
        if (i_rst_n && o_valid && !i_stall) begin
            if (result_q.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = result_q.pop_front();
                if (o_data.value !== want.value)
                    report_mismatch($sformatf("value %h, expected %h",
                                              o_data.value, want.value));
                if (o_data.error_code !== want.error_code)
                    report_mismatch($sformatf("error_code %0d, expected %0d",
                                              o_data.error_code, want.error_code));
            end
        end
    end

    initial begin
        string deep;
        int sel;
        calc_clear();
        queue_text("1+2");
        queue_text("3-4*2");
        queue_text("(1.5+2)*3/4");
        queue_text("7/0");
        queue_text("0/0");
        queue_text("0-7/0");
        queue_text("-1");
        queue_text("1.5.2");
        queue_text("2(3)");
        queue_text("2 3");
        queue_text("()");
        queue_text("(1");
        queue_text("1)");
        queue_text("1+");
        queue_text("");
        queue_text(".");
        queue_text("99999999999*99999999999");
        queue_text("123456789012345678901234");
        queue_text("1.12345678901234567890123");
        queue_text("1/3");
        queue_text("2147483647+2147483647");
        queue_text("0-2147483647-2147483647");
        deep = "";
        for (int i = 0; i < 33; i++) deep = {deep, "("};
        queue_text({deep, "1"});
        while (char_q.size() < 520 || expr_cnt < 70) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                queue_text(make_expr(2));
            end else if (sel < 9) begin
                queue_text(break_expr(make_expr(2)));
            end else begin
                deep = "";
                for (int i = $urandom_range(1, 8); i > 0; i--)
                    deep = {deep, string'(8'($urandom_range(1, 255)))};
                queue_text(deep);
            end
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (char_q.size() > 0 || i_valid);
        do @(posedge i_clk); while (result_q.size() > 0);
        repeat (500) @(posedge i_clk);
        if (fail_cnt == 0 && result_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
